// ===== design/pid_controller_clamped_unit_assert.svh =====
// assertion macros for the clamped pid unit
// expects clk and rst in the scope where a macro is used
`ifndef PID_CONTROLLER_CLAMPED_UNIT_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_UNIT_ASSERT_SVH

// same-cycle implication
`define PIDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pidc_pkg.sv =====
// shared types and constants for the clamped pid unit
// no dependencies
package pidc_pkg;

  localparam int GAIN_W         = 16;
  localparam int IN_W           = 20;
  localparam int ERR_W          = IN_W + 1;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int DRIVE_W        = 8;
  localparam int INTEG_OUT_W    = 15;
  localparam int INTEGRAL_INT_W = 7;   // signed integer part that holds +/-40
  localparam int SUM_W          = GAIN_W + DIFF_W + 2;
  localparam int CFG_INDEX_W    = 2;

  localparam int INTEGRAL_LIMIT = 40;
  localparam int DRIVE_LIMIT    = 100;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gains_t;

endpackage

// ===== design/pid_controller_clamped_unit.sv =====
// top level of the clamped pid unit: request registers, state, result register
// depends on pidc_pkg, pidc_core and pid_controller_clamped_unit_assert.svh
//
// usage
//   input channel in_valid/in_ready carries one request: target_value and
//   sensed_value, signed fixed point with FRACTION_BITS fraction bits
//   output channel out_valid/out_ready carries one result per request:
//   drive (integer, -100..100) and integral_now (clamped integral)
//   cfg_write/cfg_index/cfg_data writes the gains kp (0), ki (1), kd (2);
//   any such write clears the integral and the stored previous error,
//   index 3 is ignored; write only while no request is in flight
// timing
//   a request is captured into the input register at acceptance; the
//   combinational datapath works on it and the result register loads at the
//   first edge at which it is free or being emptied, which raises out_valid
//   throughput is one request per cycle while out_ready stays high; the
//   integral and previous-error registers update with each step
// reset
//   rst (synchronous) empties both registers and zeroes gains and state
// stall
//   while out_ready is low the result holds; one more request still enters
//   the input register, then in_ready drops until the result is taken
`include "pid_controller_clamped_unit_assert.svh"

module pid_controller_clamped_unit import pidc_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [IN_W-1:0]        target_value,
  input  logic signed [IN_W-1:0]        sensed_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DRIVE_W-1:0]     drive,
  output logic signed [INTEG_OUT_W-1:0] integral_now,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]             cfg_data
);

  localparam int IW = INTEGRAL_INT_W + FRACTION_BITS;
  localparam logic signed [IW-1:0] ILIM = IW'(INTEGRAL_LIMIT << FRACTION_BITS);

  // gains and controller state
  gains_t                  gains;
  logic signed [IW-1:0]    integral_acc;
  logic signed [ERR_W-1:0] last_error;

  // input register
  logic                    req_valid;
  logic signed [IN_W-1:0]  req_target;
  logic signed [IN_W-1:0]  req_sensed;

  // datapath results
  logic signed [IW-1:0]      integral_next;
  logic signed [ERR_W-1:0]   error_next;
  logic signed [DRIVE_W-1:0] drive_next;

  logic advance;
  logic in_fire;
  logic cfg_hit;

  // result register free, or being emptied this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !req_valid || advance;
  assign in_fire  = in_valid && in_ready;
  assign cfg_hit  = cfg_write && (cfg_index == REG_GAIN_P || cfg_index == REG_GAIN_I
                                  || cfg_index == REG_GAIN_D);

  pidc_core #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_core (
    .gains        (gains),
    .target_value (req_target),
    .sensed_value (req_sensed),
    .integral_acc (integral_acc),
    .last_error   (last_error),
    .integral_next(integral_next),
    .error        (error_next),
    .drive        (drive_next)
  );

  // control, gains and state
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid    <= 1'b0;
      out_valid    <= 1'b0;
      gains        <= '0;
      integral_acc <= '0;
      last_error   <= '0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= req_valid;
        if (req_valid) begin
          integral_acc <= integral_next;
          last_error   <= error_next;
        end
      end
      // gain write wins over a step in the same cycle
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GAIN_P: gains.kp <= $signed(cfg_data);
          REG_GAIN_I: gains.ki <= $signed(cfg_data);
          REG_GAIN_D: gains.kd <= $signed(cfg_data);
          default: ;
        endcase
        if (cfg_hit) begin
          integral_acc <= '0;
          last_error   <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_target <= target_value;
      req_sensed <= sensed_value;
    end
    if (advance && req_valid) begin
      drive        <= drive_next;
      integral_now <= INTEG_OUT_W'(integral_next);
    end
  end

  // drive stays inside its saturation band
  `PIDC_ASSERT_SAME(a_drive_range, out_valid,
    (drive <= 8'sd100) && (drive >= -8'sd100), "drive outside +/-100")
  // integral state never leaves its clamp
  `PIDC_ASSERT_SAME(a_integral_range, 1'b1,
    (integral_acc <= ILIM) && (integral_acc >= -ILIM), "integral state outside clamp")
  // a gain write clears the controller state
  `PIDC_ASSERT_NEXT(a_cfg_clears, cfg_hit,
    (integral_acc == '0) && (last_error == '0), "gain write did not clear state")
  // a request in the input register reaches the result register when it moves
  `PIDC_ASSERT_NEXT(a_req_moves, req_valid && advance, out_valid,
    "request lost between stages")

endmodule

// ===== design/pidc_core.sv =====
// combinational pid datapath: error, three products, integral clamp, drive clamp
// depends on pidc_pkg
module pidc_core import pidc_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  gains_t                                    gains,
  input  logic signed [IN_W-1:0]                    target_value,
  input  logic signed [IN_W-1:0]                    sensed_value,
  input  logic signed [INTEGRAL_INT_W+FRACTION_BITS-1:0] integral_acc,
  input  logic signed [ERR_W-1:0]                   last_error,
  output logic signed [INTEGRAL_INT_W+FRACTION_BITS-1:0] integral_next,
  output logic signed [ERR_W-1:0]                   error,
  output logic signed [DRIVE_W-1:0]                 drive
);

  localparam int IW = INTEGRAL_INT_W + FRACTION_BITS;
  localparam int PW = GAIN_W + ERR_W;
  localparam int DW = GAIN_W + DIFF_W;
  localparam int ILIM_I = INTEGRAL_LIMIT << FRACTION_BITS;
  localparam logic signed [SUM_W-1:0] ILIM = SUM_W'(ILIM_I);
  localparam logic signed [SUM_W-1:0] DLIM = SUM_W'(DRIVE_LIMIT);
  localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << FRACTION_BITS) - 1);

  logic signed [DIFF_W-1:0] err_diff;
  logic signed [PW-1:0]     prod_p;
  logic signed [PW-1:0]     prod_i;
  logic signed [DW-1:0]     prod_d;
  logic signed [SUM_W-1:0]  integ_sum;
  logic signed [SUM_W-1:0]  integ_clamped;
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  total_biased;
  logic signed [SUM_W-1:0]  whole;
  logic signed [SUM_W-1:0]  whole_clamped;

  assign error    = ERR_W'(target_value) - ERR_W'(sensed_value);
  assign err_diff = DIFF_W'(error) - DIFF_W'(last_error);

  assign prod_p = PW'(gains.kp) * PW'(error);
  assign prod_i = PW'(gains.ki) * PW'(error);
  assign prod_d = DW'(gains.kd) * DW'(err_diff);

  // products scale back by floor shift
  assign integ_sum = SUM_W'(integral_acc) + SUM_W'(prod_i >>> FRACTION_BITS);

  always_comb begin
    if (integ_sum > ILIM) begin
      integ_clamped = ILIM;
    end else if (integ_sum < -ILIM) begin
      integ_clamped = -ILIM;
    end else begin
      integ_clamped = integ_sum;
    end
  end

  assign integral_next = IW'(integ_clamped);

  assign total = SUM_W'(prod_p >>> FRACTION_BITS) + integ_clamped
               + SUM_W'(prod_d >>> FRACTION_BITS);

  // truncate toward zero: bias negatives before the floor shift
  assign total_biased = total[SUM_W-1] ? (total + FRAC_MASK) : total;
  assign whole        = total_biased >>> FRACTION_BITS;

  always_comb begin
    if (whole > DLIM) begin
      whole_clamped = DLIM;
    end else if (whole < -DLIM) begin
      whole_clamped = -DLIM;
    end else begin
      whole_clamped = whole;
    end
  end

  assign drive = DRIVE_W'(whole_clamped);

endmodule
